// ----- hw/rtl/bsa_pkg.sv -----
package bsa_pkg;

  // region and alignment limits
  localparam int unsigned REGION_BYTES   = 65536;
  localparam int unsigned MAX_ALIGN_LOG2 = 12;

  // field widths
  localparam int unsigned OFS_W   = 17;
  localparam int unsigned ALIGN_W = 4;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned AOFS_W  = OFS_W + 1;  // aligned size or start
  localparam int unsigned END_W   = OFS_W + 2;  // aligned start plus aligned size

  localparam logic [OFS_W-1:0]   REGION_LIMIT = OFS_W'(REGION_BYTES);
  localparam logic [ALIGN_W-1:0] ALIGN_MAX    = ALIGN_W'(MAX_ALIGN_LOG2);
  localparam logic [CNT_W-1:0]   CNT_MAX      = '1;

  // configuration register indexes
  localparam logic CFG_REGION_SIZE = 1'b0;
  localparam logic CFG_DEF_ALIGN   = 1'b1;

  // request kinds
  typedef enum logic [1:0] {
    REQ_ALLOC      = 2'd0,
    REQ_CHECKPOINT = 2'd1,
    REQ_RESTORE    = 2'd2,
    REQ_RESET      = 2'd3
  } req_type_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ZERO_SIZE    = 2'd1,
    ST_NO_SPACE     = 2'd2,
    ST_RESTORE_IGN  = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [OFS_W-1:0]   alloc_size;
    logic               use_default_align;
    logic [ALIGN_W-1:0] align_log2;
    logic [OFS_W-1:0]   restore_offset;
  } bsa_req_t;

  typedef struct packed {
    logic [OFS_W-1:0]   region_size;
    logic [ALIGN_W-1:0] default_align_log2;
  } bsa_cfg_t;

  typedef struct packed {
    logic [OFS_W-1:0] top;
    logic [OFS_W-1:0] peak;
    logic [CNT_W-1:0] live_count;
    logic [CNT_W-1:0] used_bytes;
    logic [CNT_W-1:0] alloc_count;
    logic [CNT_W-1:0] alloc_bytes;
    logic [CNT_W-1:0] restore_count;
    logic [CNT_W-1:0] fail_count;
  } bsa_state_t;

  // saturating counter add
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/bsa_in_stage.sv -----
module bsa_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  bsa_pkg::bsa_req_t req_i,
  output logic              valid_o,
  input  logic              take_i,
  output bsa_pkg::bsa_req_t req_o
);

  logic              valid_q, valid_d;
  bsa_pkg::bsa_req_t req_q;

  // stage frees up in the same cycle its request moves on
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ----- hw/rtl/bsa_exec.sv -----
module bsa_exec (
  input  bsa_pkg::bsa_req_t              req_i,
  input  bsa_pkg::bsa_cfg_t              cfg_i,
  input  bsa_pkg::bsa_state_t            state_i,
  output bsa_pkg::bsa_state_t            state_o,
  output bsa_pkg::status_e               status_o,
  output logic [bsa_pkg::OFS_W-1:0]      result_o
);

  logic [bsa_pkg::ALIGN_W-1:0] lg_sel, lg;
  logic [bsa_pkg::AOFS_W-1:0]  amask, asz, start;
  logic [bsa_pkg::END_W-1:0]   alloc_end;
  logic [bsa_pkg::OFS_W-1:0]   limit, freed;
  logic                        fail;

  // alignment select and clamp
  assign lg_sel = req_i.use_default_align ? cfg_i.default_align_log2 : req_i.align_log2;
  assign lg     = (lg_sel > bsa_pkg::ALIGN_MAX) ? bsa_pkg::ALIGN_MAX : lg_sel;
  assign amask  = (bsa_pkg::AOFS_W'(1) << lg) - bsa_pkg::AOFS_W'(1);

  // round size and top, then check against the effective limit
  assign asz       = ({1'b0, req_i.alloc_size} + amask) & ~amask;
  assign start     = ({1'b0, state_i.top} + amask) & ~amask;
  assign alloc_end = {1'b0, asz} + {1'b0, start};
  assign limit     = (cfg_i.region_size > bsa_pkg::REGION_LIMIT) ? bsa_pkg::REGION_LIMIT
                                                                  : cfg_i.region_size;
  assign fail      = alloc_end > {2'b00, limit};
  assign freed     = state_i.top - req_i.restore_offset;

  always_comb begin
    state_o  = state_i;
    status_o = bsa_pkg::ST_OK;
    result_o = '0;
    case (req_i.req_type)
      bsa_pkg::REQ_ALLOC: begin
        if (req_i.alloc_size == '0) begin
          status_o = bsa_pkg::ST_ZERO_SIZE;
        end else if (fail) begin
          status_o           = bsa_pkg::ST_NO_SPACE;
          state_o.fail_count = bsa_pkg::sat_add(state_i.fail_count, bsa_pkg::CNT_W'(1));
        end else begin
          state_o.top = alloc_end[bsa_pkg::OFS_W-1:0];
          if (alloc_end[bsa_pkg::OFS_W-1:0] > state_i.peak) begin
            state_o.peak = alloc_end[bsa_pkg::OFS_W-1:0];
          end
          result_o            = start[bsa_pkg::OFS_W-1:0];
          state_o.alloc_count = bsa_pkg::sat_add(state_i.alloc_count, bsa_pkg::CNT_W'(1));
          state_o.live_count  = bsa_pkg::sat_add(state_i.live_count, bsa_pkg::CNT_W'(1));
          state_o.alloc_bytes = bsa_pkg::sat_add(state_i.alloc_bytes,
                                                 bsa_pkg::CNT_W'(asz));
          state_o.used_bytes  = bsa_pkg::sat_add(state_i.used_bytes,
                                                 bsa_pkg::CNT_W'(asz));
        end
      end
      bsa_pkg::REQ_CHECKPOINT: begin
        result_o = state_i.top;
      end
      bsa_pkg::REQ_RESTORE: begin
        if (req_i.restore_offset <= state_i.top) begin
          state_o.top = req_i.restore_offset;
          state_o.used_bytes = (state_i.used_bytes > bsa_pkg::CNT_W'(freed))
                               ? state_i.used_bytes - bsa_pkg::CNT_W'(freed) : '0;
          state_o.restore_count = bsa_pkg::sat_add(state_i.restore_count,
                                                   bsa_pkg::CNT_W'(1));
        end else begin
          status_o = bsa_pkg::ST_RESTORE_IGN;
        end
      end
      bsa_pkg::REQ_RESET: begin
        state_o.top        = '0;
        state_o.live_count = '0;
        state_o.used_bytes = '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bump_stack_allocator_unit.sv -----
// channel    dir  tdata fields (low bit up)                         tuser
// s_axis     in   alloc_size, use_default_align, align_log2,         req_type
//                 restore_offset
// m_axis     out  result_offset, top_offset, high_water,             status
//                 live_allocations, bytes_in_use, total_allocs,
//                 total_bytes, total_restores, failed_allocs
// cfg        in   cfg_idx_i 0 region_size, 1 default_align_log2
//
// One request per cycle unless the result stalls; input and result are registered.
// The allocator state register feeds bsa_exec, whose output loads it back.
// Reset clears state, counters and valids and loads the default configuration.
// A stalled result holds the state; the input register still takes one more request.
module bump_stack_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [39:0]                 s_axis_tdata,  // alloc_size, use_default_align,
                                                     // align_log2, restore_offset
  input  logic [1:0]                  s_axis_tuser,  // req_type
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [247:0]                m_axis_tdata,  // result_offset, top_offset,
                                                     // high_water, live_allocations,
                                                     // bytes_in_use, total_allocs,
                                                     // total_bytes, total_restores,
                                                     // failed_allocs
  output logic [1:0]                  m_axis_tuser,  // status
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bsa_pkg::OFS_W-1:0]   cfg_wdata_i
);

  bsa_pkg::bsa_req_t   s_req, req;
  bsa_pkg::bsa_cfg_t   cfg_q;
  bsa_pkg::bsa_state_t state_q, state_d;
  bsa_pkg::status_e    status_d, status_q;
  logic [bsa_pkg::OFS_W-1:0] result_d, result_q;
  logic req_valid, advance, out_valid_q, out_valid_d;

  // unpack the incoming request
  assign s_req.req_type          = bsa_pkg::req_type_e'(s_axis_tuser);
  assign s_req.alloc_size        = s_axis_tdata[16:0];
  assign s_req.use_default_align = s_axis_tdata[17];
  assign s_req.align_log2        = s_axis_tdata[21:18];
  assign s_req.restore_offset    = s_axis_tdata[38:22];

  bsa_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .req_i   (s_req),
    .valid_o (req_valid),
    .take_i  (advance),
    .req_o   (req)
  );

  bsa_exec u_exec (
    .req_i    (req),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .status_o (status_d),
    .result_o (result_d)
  );

  // request moves into the result register when that is free or drains
  assign advance = req_valid && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_size        <= bsa_pkg::REGION_LIMIT;
      cfg_q.default_align_log2 <= bsa_pkg::ALIGN_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsa_pkg::CFG_REGION_SIZE: cfg_q.region_size <= cfg_wdata_i;
        bsa_pkg::CFG_DEF_ALIGN: begin
          cfg_q.default_align_log2 <= cfg_wdata_i[bsa_pkg::ALIGN_W-1:0];
        end
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // allocator state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      result_q <= result_d;
    end
  end

  // state registers change only when the result register loads, so they
  // hold the post-request snapshot for the waiting result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {5'b0,
                          state_q.fail_count, state_q.restore_count,
                          state_q.alloc_bytes, state_q.alloc_count,
                          state_q.used_bytes, state_q.live_count,
                          state_q.peak, state_q.top, result_q};

`ifndef SYNTHESIS
  a_top_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.top <= bsa_pkg::REGION_LIMIT)
    else $error("top beyond region");

  a_peak_covers_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.top <= state_q.peak)
    else $error("high water below top");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(state_q))
    else $error("state changed under stalled result");

  a_allocs_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> state_q.alloc_count >= $past(state_q.alloc_count))
    else $error("total allocs decreased");

  a_used_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.used_bytes <= state_q.alloc_bytes)
    else $error("bytes in use above total bytes");
`endif

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import bsa_pkg::*;

  localparam int unsigned IN_W        = 40;
  localparam int unsigned OUT_W       = 248;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_REQS  = 105;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct {
    status_e          status;
    logic [OFS_W-1:0] result_offset;
    logic [OFS_W-1:0] top_offset;
    logic [OFS_W-1:0] high_water;
    logic [CNT_W-1:0] live_allocations;
    logic [CNT_W-1:0] bytes_in_use;
    logic [CNT_W-1:0] total_allocs;
    logic [CNT_W-1:0] total_bytes;
    logic [CNT_W-1:0] total_restores;
    logic [CNT_W-1:0] failed_allocs;
  } alloc_result_t;

  typedef struct {
    bit               is_cfg;
    logic             reg_idx;
    int unsigned      reg_val;
    bsa_req_t         req;
    bit               typed;
    status_e          t_status;
    logic [OFS_W-1:0] t_top;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;
  logic [1:0]         s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [OFS_W-1:0]   cfg_wdata_i;

  // allocator state as the testbench sees it
  logic [OFS_W-1:0]   cur_region    = OFS_W'(REGION_BYTES);
  logic [ALIGN_W-1:0] cur_def_align = ALIGN_W'(3);
  logic [OFS_W-1:0]   stack_top     = '0;
  logic [OFS_W-1:0]   peak_top      = '0;
  logic [CNT_W-1:0]   live_cnt      = '0;
  logic [CNT_W-1:0]   inuse_bytes   = '0;
  logic [CNT_W-1:0]   ok_allocs     = '0;
  logic [CNT_W-1:0]   ok_bytes      = '0;
  logic [CNT_W-1:0]   restores      = '0;
  logic [CNT_W-1:0]   refusals      = '0;

  alloc_result_t pending_results[$];
  dir_row_t      directed_rows[$];
  int unsigned   error_count  = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   tx_idle_pct  = 24;
  int unsigned   rx_idle_pct  = 80;
  int unsigned   rx_hold_left = 0;

  int unsigned phase_region[PHASES] = '{65536, 4096, 1, 131071, 1000, 300};
  int unsigned phase_align[PHASES]  = '{3, 12, 0, 15, 6, 2};

  bump_stack_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // saturating 32-bit counter step
  function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] a,
                                                input logic [63:0] b);
    logic [63:0] s;
    s = 64'(a) + b;
    return (s > 64'hFFFF_FFFF) ? '1 : s[CNT_W-1:0];
  endfunction

  // next allocator state and the result of one request
  function automatic alloc_result_t predict_request(input bsa_req_t r);
    alloc_result_t o;
    logic [63:0] lg, msk, asz, start, end_ofs, lim, freed;
    o.status = ST_OK;
    o.result_offset = '0;
    case (r.req_type)
      REQ_ALLOC: begin
        if (r.alloc_size == '0) begin
          o.status = ST_ZERO_SIZE;
        end else begin
          lim = (64'(cur_region) > 64'(REGION_BYTES)) ? 64'(REGION_BYTES) : 64'(cur_region);
          lg = r.use_default_align ? 64'(cur_def_align) : 64'(r.align_log2);
          if (lg > 64'(MAX_ALIGN_LOG2)) lg = 64'(MAX_ALIGN_LOG2);
          msk = (64'd1 << lg) - 64'd1;
          asz = (64'(r.alloc_size) + msk) & ~msk;
          start = (64'(stack_top) + msk) & ~msk;
          end_ofs = start + asz;
          if (end_ofs > lim) begin
            o.status = ST_NO_SPACE;
            refusals = bump_sat(refusals, 64'd1);
          end else begin
            stack_top = end_ofs[OFS_W-1:0];
            if (stack_top > peak_top) peak_top = stack_top;
            o.result_offset = start[OFS_W-1:0];
            ok_allocs   = bump_sat(ok_allocs, 64'd1);
            live_cnt    = bump_sat(live_cnt, 64'd1);
            ok_bytes    = bump_sat(ok_bytes, asz);
            inuse_bytes = bump_sat(inuse_bytes, asz);
          end
        end
      end
      REQ_CHECKPOINT: begin
        o.result_offset = stack_top;
      end
      REQ_RESTORE: begin
        if (r.restore_offset <= stack_top) begin
          freed = 64'(stack_top) - 64'(r.restore_offset);
          stack_top = r.restore_offset;
          inuse_bytes = (64'(inuse_bytes) > freed) ? CNT_W'(64'(inuse_bytes) - freed) : '0;
          restores = bump_sat(restores, 64'd1);
        end else begin
          o.status = ST_RESTORE_IGN;
        end
      end
      default: begin
        stack_top   = '0;
        live_cnt    = '0;
        inuse_bytes = '0;
      end
    endcase
    o.top_offset       = stack_top;
    o.high_water       = peak_top;
    o.live_allocations = live_cnt;
    o.bytes_in_use     = inuse_bytes;
    o.total_allocs     = ok_allocs;
    o.total_bytes      = ok_bytes;
    o.total_restores   = restores;
    o.failed_allocs    = refusals;
    return o;
  endfunction

  // directed table builders
  function automatic void add_req(input req_type_e k, input int unsigned sz, input bit dflt,
                                  input int unsigned lg, input int unsigned ofs,
                                  input bit typed, input status_e st, input int unsigned tp);
    dir_row_t row;
    row.is_cfg                = 1'b0;
    row.reg_idx               = CFG_REGION_SIZE;
    row.reg_val               = 0;
    row.req.req_type          = k;
    row.req.alloc_size        = OFS_W'(sz);
    row.req.use_default_align = dflt;
    row.req.align_log2        = ALIGN_W'(lg);
    row.req.restore_offset    = OFS_W'(ofs);
    row.typed                 = typed;
    row.t_status              = st;
    row.t_top                 = OFS_W'(tp);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic idx, input int unsigned val);
    dir_row_t row;
    row.is_cfg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    row.req      = '0;
    row.typed    = 1'b0;
    row.t_status = ST_OK;
    row.t_top    = '0;
    directed_rows.push_back(row);
  endfunction

  // random request, mostly well-formed against the current stack top
  function automatic bsa_req_t random_request();
    bsa_req_t    r;
    int unsigned pick, sz_pick, lim;
    lim = (32'(cur_region) > REGION_BYTES) ? REGION_BYTES : 32'(cur_region);
    pick    = $urandom_range(99);
    sz_pick = $urandom_range(99);
    r.use_default_align = 1'($urandom_range(1));
    r.align_log2 = ($urandom_range(3) == 0) ? ALIGN_W'($urandom_range(15))
                                            : ALIGN_W'($urandom_range(4));
    r.restore_offset = OFS_W'($urandom);
    if (sz_pick < 5) r.alloc_size = '0;
    else if (sz_pick < 75) r.alloc_size = OFS_W'($urandom_range(64, 1));
    else if (sz_pick < 90) r.alloc_size = OFS_W'($urandom_range(lim / 4 + 1, 1));
    else r.alloc_size = OFS_W'($urandom);
    if (pick < 55) begin
      r.req_type = REQ_ALLOC;
    end else if (pick < 70) begin
      r.req_type = REQ_CHECKPOINT;
    end else if (pick < 94) begin
      r.req_type = REQ_RESTORE;
      if ($urandom_range(3) != 0) r.restore_offset = OFS_W'($urandom_range(int'(stack_top), 0));
    end else begin
      r.req_type = REQ_RESET;
    end
    return r;
  endfunction

  // offer one request, called and left at a falling edge
  task automatic send_request(input bsa_req_t r, input bit typed, input status_e t_status,
                              input logic [OFS_W-1:0] t_top);
    alloc_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r.restore_offset, r.align_log2, r.use_default_align, r.alloc_size};
    s_axis_tuser  <= r.req_type;
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_request(r);
    if (typed) begin
      res.status     = t_status;
      res.top_offset = t_top;
    end
    pending_results.push_back(res);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= OFS_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_REGION_SIZE) cur_region = OFS_W'(val);
    else cur_def_align = ALIGN_W'(val);
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", CNT_W'(m_axis_tuser), CNT_W'(want.status));
        check_field("result_offset", CNT_W'(m_axis_tdata[0 +: OFS_W]),
                    CNT_W'(want.result_offset));
        check_field("top_offset", CNT_W'(m_axis_tdata[OFS_W +: OFS_W]),
                    CNT_W'(want.top_offset));
        check_field("high_water", CNT_W'(m_axis_tdata[2*OFS_W +: OFS_W]),
                    CNT_W'(want.high_water));
        check_field("live_allocations", m_axis_tdata[3*OFS_W +: CNT_W],
                    want.live_allocations);
        check_field("bytes_in_use", m_axis_tdata[3*OFS_W+CNT_W +: CNT_W], want.bytes_in_use);
        check_field("total_allocs", m_axis_tdata[3*OFS_W+2*CNT_W +: CNT_W], want.total_allocs);
        check_field("total_bytes", m_axis_tdata[3*OFS_W+3*CNT_W +: CNT_W], want.total_bytes);
        check_field("total_restores", m_axis_tdata[3*OFS_W+4*CNT_W +: CNT_W],
                    want.total_restores);
        check_field("failed_allocs", m_axis_tdata[3*OFS_W+5*CNT_W +: CNT_W],
                    want.failed_allocs);
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = 1'b0;
    cfg_wdata_i   = '0;

    // directed: reset state, rounding, clamped alignment, limits, restores, resets
    add_req(REQ_CHECKPOINT, 0, 0, 0, 0, 1, ST_OK, 0);
    add_req(REQ_ALLOC, 0, 0, 15, 0, 1, ST_ZERO_SIZE, 0);
    add_req(REQ_ALLOC, 1, 1, 0, 0, 1, ST_OK, 8);
    add_req(REQ_ALLOC, 5, 0, 0, 0, 1, ST_OK, 13);
    add_req(REQ_ALLOC, 3, 0, 15, 0, 1, ST_OK, 8192);
    add_req(REQ_CHECKPOINT, 0, 0, 0, 0, 0, ST_OK, 0);
    add_req(REQ_RESTORE, 0, 0, 0, 13, 1, ST_OK, 13);
    add_req(REQ_RESTORE, 0, 0, 0, 100, 1, ST_RESTORE_IGN, 13);
    add_req(REQ_ALLOC, 65536, 1, 0, 0, 1, ST_NO_SPACE, 13);
    add_req(REQ_ALLOC, 131071, 0, 0, 131071, 1, ST_NO_SPACE, 13);
    add_req(REQ_RESET, 0, 0, 0, 0, 1, ST_OK, 0);
    add_req(REQ_ALLOC, 65536, 0, 0, 131071, 1, ST_OK, 65536);
    add_req(REQ_CHECKPOINT, 0, 0, 0, 0, 1, ST_OK, 65536);
    add_req(REQ_ALLOC, 1, 1, 0, 0, 1, ST_NO_SPACE, 65536);
    add_req(REQ_RESTORE, 131071, 1, 15, 131071, 1, ST_RESTORE_IGN, 65536);
    add_req(REQ_RESTORE, 0, 0, 0, 65536, 1, ST_OK, 65536);
    // region shrunk below the top
    add_cfg(CFG_REGION_SIZE, 100);
    add_req(REQ_ALLOC, 1, 0, 0, 0, 1, ST_NO_SPACE, 65536);
    add_req(REQ_RESTORE, 0, 0, 0, 0, 1, ST_OK, 0);
    add_req(REQ_ALLOC, 100, 0, 0, 0, 1, ST_OK, 100);
    // empty region
    add_cfg(CFG_REGION_SIZE, 0);
    add_req(REQ_ALLOC, 1, 0, 0, 0, 1, ST_NO_SPACE, 100);
    // oversized region and default alignment are clamped
    add_cfg(CFG_REGION_SIZE, 131071);
    add_cfg(CFG_DEF_ALIGN, 15);
    add_req(REQ_ALLOC, 1, 1, 0, 0, 1, ST_OK, 8192);
    add_req(REQ_ALLOC, 2, 1, 5, 0, 0, ST_OK, 0);
    add_cfg(CFG_DEF_ALIGN, 0);
    add_req(REQ_ALLOC, 7, 1, 12, 0, 0, ST_OK, 0);
    add_req(REQ_CHECKPOINT, 0, 0, 0, 0, 0, ST_OK, 0);
    add_req(REQ_RESET, 0, 0, 0, 0, 1, ST_OK, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_request(directed_rows[i].req, directed_rows[i].typed,
                     directed_rows[i].t_status, directed_rows[i].t_top);
    end

    // random phases, each with its own configuration; the idle pattern changes every two phases
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_REGION_SIZE, phase_region[p]);
      write_reg(CFG_DEF_ALIGN, phase_align[p]);
      if (p < 2) begin
        tx_idle_pct = 24;
        rx_idle_pct = 80;
      end else if (p < 4) begin
        tx_idle_pct = 80;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver hold-off while the sender keeps pushing
      if (p == 4) rx_hold_left = 150;
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n == PHASE_REQS / 2) drain_results();
        send_request(random_request(), 1'b0, ST_OK, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
